@@ rtl/bac_pkg.sv @@
package bac_pkg;

  // Fixed field widths of the interface.
  localparam int CFG_W     = 9;
  localparam int CFG_IDX_W = 1;
  localparam int PIX_W     = 8;
  localparam int COLOR_W   = 3 * PIX_W;
  localparam int CROP_W    = 9;

  // Default frame store geometry.
  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;

  // Reset value of both size registers.
  localparam logic [CFG_W-1:0] DIM_RESET = 9'd256;

  localparam logic [PIX_W-1:0] ALPHA_OPAQUE = 8'd255;
  localparam logic [PIX_W-1:0] ALPHA_CLEAR  = 8'd0;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_FETCH = 1'b1
  } op_t;

  typedef enum logic {
    KIND_SUMMARY = 1'b0,
    KIND_PIXEL   = 1'b1
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 1'd0,
    REG_IMAGE_HEIGHT = 1'd1
  } cfg_reg_t;

  // One result on its way from the control logic to the output stage.
  typedef struct packed {
    logic                valid;
    kind_t               kind;
    logic                last;
    logic                empty;
    logic [CROP_W-1:0]   crop_width;
    logic [CROP_W-1:0]   crop_height;
    logic [COLOR_W-1:0]  bg;
  } bac_res_t;

endpackage

@@ rtl/bac_frame_mem.sv @@
module bac_frame_mem #(
  parameter int DEPTH = bac_pkg::DEF_MAX_WIDTH * bac_pkg::DEF_MAX_HEIGHT,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [AW-1:0]               wr_addr,
  input  logic [bac_pkg::COLOR_W-1:0] wr_data,
  input  logic                        rd_en,
  input  logic [AW-1:0]               rd_addr,
  output logic [bac_pkg::COLOR_W-1:0] rd_data
);
  import bac_pkg::*;

  logic [COLOR_W-1:0] mem [DEPTH];
  logic [COLOR_W-1:0] rd_data_r;

  // Single write port, registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/bac_ctrl.sv @@
module bac_ctrl #(
  parameter int MAX_WIDTH  = bac_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = bac_pkg::DEF_MAX_HEIGHT,
  parameter int AW         = $clog2(MAX_WIDTH * MAX_HEIGHT)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          accept,
  input  bac_pkg::op_t                  op,
  input  logic [bac_pkg::COLOR_W-1:0]   colour,
  input  logic                          cfg_we,
  input  logic [bac_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bac_pkg::CFG_W-1:0]     cfg_data,
  output logic                          mem_we,
  output logic [AW-1:0]                 mem_waddr,
  output logic [bac_pkg::COLOR_W-1:0]   mem_wdata,
  output logic                          mem_re,
  output logic [AW-1:0]                 mem_raddr,
  output bac_pkg::bac_res_t             res
);
  import bac_pkg::*;

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int DWW = $clog2(MAX_WIDTH + 1);
  localparam int DHW = $clog2(MAX_HEIGHT + 1);
  localparam logic [AW-1:0] ROW_PITCH = AW'(MAX_WIDTH);

  // Configuration and frame bookkeeping registers.
  logic [CFG_W-1:0]   img_w_r, img_w_nxt;
  logic [CFG_W-1:0]   img_h_r, img_h_nxt;
  logic [COLOR_W-1:0] bg_r, bg_nxt;
  logic [CW-1:0]      left_r, left_nxt, right_r, right_nxt;
  logic [RW-1:0]      top_r, top_nxt, bot_r, bot_nxt;
  logic               found_r, found_nxt;
  logic [CW-1:0]      lcol_r, lcol_nxt;
  logic [RW-1:0]      lrow_r, lrow_nxt;
  logic               complete_r, complete_nxt;
  logic [CW-1:0]      rcol_r, rcol_nxt;
  logic [RW-1:0]      rrow_r, rrow_nxt;
  logic               active_r, active_nxt;

  // Working values of the current request.
  logic [DWW-1:0] eff_w;
  logic [DHW-1:0] eff_h;
  logic [CW-1:0]  col_c, left_c, right_c;
  logic [RW-1:0]  row_c, top_c, bot_c;
  logic           found_c;
  logic [DWW-1:0] box_w;
  logic [DHW-1:0] box_h;
  logic [CW-1:0]  fetch_col;
  logic [RW-1:0]  fetch_row;
  logic           fetch_last;

  // Out-of-range sizes are clamped to one and to the store geometry.
  always_comb begin
    if (img_w_r == '0) begin
      eff_w = DWW'(1);
    end else if (32'(img_w_r) > MAX_WIDTH) begin
      eff_w = DWW'(MAX_WIDTH);
    end else begin
      eff_w = DWW'(img_w_r);
    end
    if (img_h_r == '0) begin
      eff_h = DHW'(1);
    end else if (32'(img_h_r) > MAX_HEIGHT) begin
      eff_h = DHW'(MAX_HEIGHT);
    end else begin
      eff_h = DHW'(img_h_r);
    end
  end

  // Size of the stored box, used by the readout.
  assign box_w = DWW'(right_r) - DWW'(left_r) + DWW'(1);
  assign box_h = DHW'(bot_r) - DHW'(top_r) + DHW'(1);

  // Readout position inside the box.
  assign fetch_col  = left_r + rcol_r;
  assign fetch_row  = top_r + rrow_r;
  assign fetch_last = (DWW'(rcol_r) + DWW'(1) >= box_w) &&
                      (DHW'(rrow_r) + DHW'(1) >= box_h);

  // Next state, memory requests and result for the accepted request.
  always_comb begin
    img_w_nxt    = img_w_r;
    img_h_nxt    = img_h_r;
    bg_nxt       = bg_r;
    left_nxt     = left_r;
    right_nxt    = right_r;
    top_nxt      = top_r;
    bot_nxt      = bot_r;
    found_nxt    = found_r;
    lcol_nxt     = lcol_r;
    lrow_nxt     = lrow_r;
    complete_nxt = complete_r;
    rcol_nxt     = rcol_r;
    rrow_nxt     = rrow_r;
    active_nxt   = active_r;

    col_c   = lcol_r;
    row_c   = lrow_r;
    left_c  = left_r;
    right_c = right_r;
    top_c   = top_r;
    bot_c   = bot_r;
    found_c = found_r;

    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = colour;
    mem_re    = 1'b0;
    mem_raddr = '0;
    res       = '0;
    res.bg    = bg_r;

    if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_IMAGE_WIDTH:  img_w_nxt = cfg_data;
        REG_IMAGE_HEIGHT: img_h_nxt = cfg_data;
        default: ;
      endcase
    end

    if (accept && op == OP_LOAD) begin
      // A load after a complete frame discards it and starts a new one.
      if (complete_r) begin
        col_c      = '0;
        row_c      = '0;
        left_c     = '0;
        right_c    = '0;
        top_c      = '0;
        bot_c      = '0;
        found_c    = 1'b0;
        active_nxt = 1'b0;
      end
      // The first pixel of a frame is the background.
      if (col_c == '0 && row_c == '0) begin
        bg_nxt  = colour;
        found_c = 1'b0;
      end
      mem_we    = 1'b1;
      mem_waddr = AW'(row_c) * ROW_PITCH + AW'(col_c);

      left_nxt  = left_c;
      right_nxt = right_c;
      top_nxt   = top_c;
      bot_nxt   = bot_c;
      found_nxt = found_c;
      if (colour != bg_nxt) begin
        if (!found_c) begin
          left_nxt  = col_c;
          right_nxt = col_c;
          top_nxt   = row_c;
          bot_nxt   = row_c;
          found_nxt = 1'b1;
        end else begin
          if (col_c < left_c)  left_nxt  = col_c;
          if (col_c > right_c) right_nxt = col_c;
          if (row_c < top_c)   top_nxt   = row_c;
          if (row_c > bot_c)   bot_nxt   = row_c;
        end
      end

      complete_nxt = 1'b0;
      if (DWW'(col_c) + DWW'(1) >= eff_w) begin
        lcol_nxt = '0;
        if (DHW'(row_c) + DHW'(1) >= eff_h) begin
          // Last pixel of the frame: issue the summary with the updated box.
          lrow_nxt     = '0;
          complete_nxt = 1'b1;
          active_nxt   = found_nxt;
          rcol_nxt     = '0;
          rrow_nxt     = '0;
          res.valid    = 1'b1;
          res.kind     = KIND_SUMMARY;
          if (found_nxt) begin
            res.crop_width  = CROP_W'(right_nxt) - CROP_W'(left_nxt) + CROP_W'(1);
            res.crop_height = CROP_W'(bot_nxt) - CROP_W'(top_nxt) + CROP_W'(1);
          end else begin
            res.empty = 1'b1;
          end
        end else begin
          lrow_nxt = row_c + RW'(1);
        end
      end else begin
        lcol_nxt = col_c + CW'(1);
        lrow_nxt = row_c;
      end
    end else if (accept && op == OP_FETCH && active_r) begin
      // Read one pixel of the box; the output stage keys it.
      mem_re    = 1'b1;
      mem_raddr = AW'(fetch_row) * ROW_PITCH + AW'(fetch_col);
      res.valid = 1'b1;
      res.kind  = KIND_PIXEL;
      res.last  = fetch_last;
      if (fetch_last) begin
        active_nxt = 1'b0;
        rcol_nxt   = '0;
        rrow_nxt   = '0;
      end else if (DWW'(rcol_r) + DWW'(1) >= box_w) begin
        rcol_nxt = '0;
        rrow_nxt = rrow_r + RW'(1);
      end else begin
        rcol_nxt = rcol_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_w_r    <= DIM_RESET;
      img_h_r    <= DIM_RESET;
      bg_r       <= '0;
      left_r     <= '0;
      right_r    <= '0;
      top_r      <= '0;
      bot_r      <= '0;
      found_r    <= 1'b0;
      lcol_r     <= '0;
      lrow_r     <= '0;
      complete_r <= 1'b0;
      rcol_r     <= '0;
      rrow_r     <= '0;
      active_r   <= 1'b0;
    end else begin
      img_w_r    <= img_w_nxt;
      img_h_r    <= img_h_nxt;
      bg_r       <= bg_nxt;
      left_r     <= left_nxt;
      right_r    <= right_nxt;
      top_r      <= top_nxt;
      bot_r      <= bot_nxt;
      found_r    <= found_nxt;
      lcol_r     <= lcol_nxt;
      lrow_r     <= lrow_nxt;
      complete_r <= complete_nxt;
      rcol_r     <= rcol_nxt;
      rrow_r     <= rrow_nxt;
      active_r   <= active_nxt;
    end
  end

endmodule

@@ rtl/bac_out.sv @@
module bac_out (
  input  logic                        clk,
  input  logic                        rst_n,
  input  bac_pkg::bac_res_t           res,
  input  logic [bac_pkg::COLOR_W-1:0] rd_data,
  input  logic                        out_stall,
  output logic                        in_stall,
  output logic                        out_valid,
  output logic                        out_kind,
  output logic [bac_pkg::PIX_W-1:0]   out_red,
  output logic [bac_pkg::PIX_W-1:0]   out_green,
  output logic [bac_pkg::PIX_W-1:0]   out_blue,
  output logic [bac_pkg::PIX_W-1:0]   out_alpha,
  output logic [bac_pkg::CROP_W-1:0]  out_crop_width,
  output logic [bac_pkg::CROP_W-1:0]  out_crop_height,
  output logic                        out_empty_res,
  output logic                        out_last
);
  import bac_pkg::*;

  bac_res_t          p1_r;
  logic              out_valid_r;
  logic              out_kind_r;
  logic [PIX_W-1:0]  out_red_r, out_green_r, out_blue_r, out_alpha_r;
  logic [CROP_W-1:0] out_cw_r, out_ch_r;
  logic              out_empty_r, out_last_r;
  logic              out_free;
  logic              advance;

  // The result stage moves on whenever the output register is free or drained.
  assign out_free = !out_valid_r || !out_stall;
  assign advance  = p1_r.valid && out_free;
  assign in_stall = p1_r.valid && !out_free;

  // Result stage: holds the result while the store read data is registered.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_r <= '0;
    end else if (advance || !p1_r.valid) begin
      p1_r <= res;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_kind_r <= p1_r.kind;
      if (p1_r.kind == KIND_PIXEL) begin
        out_red_r   <= rd_data[3*PIX_W-1:2*PIX_W];
        out_green_r <= rd_data[2*PIX_W-1:PIX_W];
        out_blue_r  <= rd_data[PIX_W-1:0];
        out_alpha_r <= (rd_data == p1_r.bg) ? ALPHA_CLEAR : ALPHA_OPAQUE;
        out_last_r  <= p1_r.last;
        out_cw_r    <= '0;
        out_ch_r    <= '0;
        out_empty_r <= 1'b0;
      end else begin
        out_red_r   <= '0;
        out_green_r <= '0;
        out_blue_r  <= '0;
        out_alpha_r <= '0;
        out_last_r  <= 1'b0;
        out_cw_r    <= p1_r.crop_width;
        out_ch_r    <= p1_r.crop_height;
        out_empty_r <= p1_r.empty;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = out_kind_r;
  assign out_red         = out_red_r;
  assign out_green       = out_green_r;
  assign out_blue        = out_blue_r;
  assign out_alpha       = out_alpha_r;
  assign out_crop_width  = out_cw_r;
  assign out_crop_height = out_ch_r;
  assign out_empty_res   = out_empty_r;
  assign out_last        = out_last_r;

endmodule

@@ rtl/background_autocrop_alpha_key_top.sv @@
// Background autocrop with color-key alpha. Loads (op 0) write one RGB pixel each into a
// MAX_WIDTH x MAX_HEIGHT frame store in raster order; the first pixel of a frame is the
// background, and the last one returns a summary with the crop size and an empty flag.
// Fetches (op 1) then read the cropped box row by row, one pixel each, with alpha 0 for
// background pixels and 255 otherwise. One request is accepted every clock unless in_stall is
// high; each one is a single access to the single-port-per-direction frame store. A result
// passes from the result stage, alongside the registered store read data, to the output
// register. in_stall rises only while both the result stage and the output register are full.
// There is no clearing pass after reset; the store is read only where a frame was written.
module background_autocrop_alpha_key_top #(
  parameter int MAX_WIDTH  = bac_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = bac_pkg::DEF_MAX_HEIGHT
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_op,
  input  logic [bac_pkg::PIX_W-1:0]     in_red,
  input  logic [bac_pkg::PIX_W-1:0]     in_green,
  input  logic [bac_pkg::PIX_W-1:0]     in_blue,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_kind,
  output logic [bac_pkg::PIX_W-1:0]     out_red,
  output logic [bac_pkg::PIX_W-1:0]     out_green,
  output logic [bac_pkg::PIX_W-1:0]     out_blue,
  output logic [bac_pkg::PIX_W-1:0]     out_alpha,
  output logic [bac_pkg::CROP_W-1:0]    out_crop_width,
  output logic [bac_pkg::CROP_W-1:0]    out_crop_height,
  output logic                          out_empty_res,
  output logic                          out_last,
  input  logic                          cfg_we,
  input  logic [bac_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bac_pkg::CFG_W-1:0]     cfg_data
);
  import bac_pkg::*;

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);

  logic               accept;
  logic               mem_we, mem_re;
  logic [AW-1:0]      mem_waddr, mem_raddr;
  logic [COLOR_W-1:0] mem_wdata, mem_rdata;
  bac_res_t           res;

  assign accept = in_valid && !in_stall;

  bac_ctrl #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .AW         (AW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .op        (op_t'(in_op)),
    .colour    ({in_red, in_green, in_blue}),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .res       (res)
  );

  bac_frame_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_en   (mem_re),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  bac_out u_out (
    .clk             (clk),
    .rst_n           (rst_n),
    .res             (res),
    .rd_data         (mem_rdata),
    .out_stall       (out_stall),
    .in_stall        (in_stall),
    .out_valid       (out_valid),
    .out_kind        (out_kind),
    .out_red         (out_red),
    .out_green       (out_green),
    .out_blue        (out_blue),
    .out_alpha       (out_alpha),
    .out_crop_width  (out_crop_width),
    .out_crop_height (out_crop_height),
    .out_empty_res   (out_empty_res),
    .out_last        (out_last)
  );

  // The input is held back only when a finished result cannot leave.
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while the output register could drain");

  // A store read always carries a pixel result along with it.
  a_read_has_result: assert property (@(posedge clk) disable iff (!rst_n)
    mem_re |-> (res.valid && res.kind == KIND_PIXEL))
    else $error("store read without a pixel result");

  // Loads and fetches never touch the store in the same cycle.
  a_one_access: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_we && mem_re))
    else $error("store written and read in one cycle");

  // An empty frame reports a zero box.
  a_empty_zero_box: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_empty_res) |->
      (out_kind == KIND_SUMMARY && out_crop_width == '0 && out_crop_height == '0))
    else $error("empty summary with a nonzero box");

endmodule
